// ----- rtl/core/dtdc_pkg.sv -----
// Shared constants and types for the double to decimal character converter.
// No dependencies; every other file in rtl/core uses this package.
`default_nettype none

package dtdc_pkg;

    // Field widths of the two channels.
    localparam int VALUE_W = 64;
    localparam int PREC_W  = 5;
    localparam int CHAR_W  = 8;

    // Digits after the point are capped at this count.
    localparam logic [PREC_W-1:0] PREC_MAX = 5'd27;

    // Guard on the number of integer digits found by dividing.
    localparam logic [4:0] INT_LIMIT = 5'd16;

    // Binary64 exponent field values.
    localparam logic [10:0] EXP_ONE   = 11'd1023;  // magnitude 1.0
    localparam logic [10:0] EXP_LIMIT = 11'd1054;  // magnitude 2^31
    localparam logic [11:0] EXP_BIAS  = 12'd1023;

    // Exponent offsets applied after rounding a product or a quotient.
    localparam logic [11:0] EXP_ADJ_MUL = 12'd3;
    localparam logic [11:0] EXP_ADJ_DIV = 12'hFFC;  // minus four

    // ASCII codes.
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_NONE  = 8'h00;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_start;
        logic mul;
        logic round;
        logic sub;
        logic norm;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic              err;
        logic              neg;
        logic              below_one;
        logic              ge_one;
        logic              div_busy;
        logic              norm_done;
        logic [CHAR_W-1:0] digit_char;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- rtl/core/dtdc_if.sv -----
// Channel interfaces of the converter: input item and result character.
// Depends on dtdc_pkg for the field widths.
`default_nettype none

interface dtdc_in_if;
    logic                          valid;
    logic                          ready;
    logic [dtdc_pkg::VALUE_W-1:0]  value_bits;
    logic [dtdc_pkg::PREC_W-1:0]   precision;

    modport source (output valid, output value_bits, output precision, input ready);
    modport sink   (input valid, input value_bits, input precision, output ready);
endinterface

interface dtdc_out_if;
    logic                          valid;
    logic                          ready;
    logic [dtdc_pkg::CHAR_W-1:0]   character;
    logic                          last;
    logic                          out_of_range;

    modport source (output valid, output character, output last, output out_of_range,
                    input ready);
    modport sink   (input valid, input character, input last, input out_of_range,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/core/dtdc_datapath.sv -----
// Datapath: working double (mantissa, exponent), iterative divide by ten,
// multiply by ten, round to nearest even, digit extraction and normalizer.
// Depends on dtdc_pkg.
`default_nettype none

module dtdc_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dtdc_pkg::t_dp_cmd             i_cmd,
    input  logic [dtdc_pkg::VALUE_W-1:0]  i_value_bits,
    output dtdc_pkg::t_dp_stat            o_stat
);
    import dtdc_pkg::*;

    // Working value is r_m * 2^(r_e - 52) with r_m[52] set, unless r_zero.
    logic [52:0] r_m;
    logic [11:0] r_e;
    logic        r_zero;
    logic        r_neg;
    logic        r_err;
    logic        r_small;

    // Shared wide register: dividend/quotient while dividing, product after multiply.
    logic [63:0] r_dq;
    logic [3:0]  r_rem;
    logic        r_from_div;
    logic        r_div_busy;
    logic [2:0]  r_div_cnt;

    // Input decode.
    logic [10:0] ld_exp;
    logic [51:0] ld_frac;
    assign ld_exp  = i_value_bits[62:52];
    assign ld_frac = i_value_bits[51:0];

    // Eight restoring division steps by ten per cycle.
    logic [63:0] div_dq;
    logic [3:0]  div_rem;
    always_comb begin
        logic [4:0] t5;
        logic       qb;
        div_dq  = r_dq;
        div_rem = r_rem;
        for (int i = 0; i < 8; i++) begin
            t5      = {div_rem, div_dq[63]};
            qb      = (t5 >= 5'd10);
            div_rem = qb ? 4'(t5 - 5'd10) : t5[3:0];
            div_dq  = {div_dq[62:0], qb};
        end
    end

    // Multiply by ten as two shifted adds.
    logic [56:0] mul_p;
    assign mul_p = {1'b0, r_m, 3'b000} + {3'b000, r_m, 1'b0};

    // Round the 57-bit product or quotient to 53 bits, ties to even.
    logic        rnd_top;
    logic [52:0] rnd_keep;
    logic        rnd_guard;
    logic        rnd_sticky;
    logic        rnd_inc;
    logic [53:0] rnd_sum;
    logic        rnd_carry;
    logic [52:0] rnd_m;
    logic [11:0] rnd_e;
    always_comb begin
        rnd_top    = r_dq[56];
        rnd_keep   = rnd_top ? r_dq[56:4] : r_dq[55:3];
        rnd_guard  = rnd_top ? r_dq[3] : r_dq[2];
        rnd_sticky = (rnd_top ? (|r_dq[2:0]) : (|r_dq[1:0])) | (|r_rem);
        rnd_inc    = rnd_guard & (rnd_sticky | rnd_keep[0]);
        rnd_sum    = {1'b0, rnd_keep} + {53'd0, rnd_inc};
        rnd_carry  = rnd_sum[53];
        rnd_m      = rnd_carry ? rnd_sum[53:1] : rnd_sum[52:0];
        rnd_e      = r_e + (r_from_div ? EXP_ADJ_DIV : EXP_ADJ_MUL)
                     + {11'd0, rnd_top} + {11'd0, rnd_carry};
    end

    // Integer digit of a value below sixteen, clamped to nine.
    logic        dig_in_range;
    logic        dig_big;
    logic [3:0]  dig_ip;
    logic [3:0]  dig_d;
    logic [55:0] dig_sub;
    logic [52:0] sub_m;
    always_comb begin
        dig_in_range = !r_zero && !r_e[11] && (r_e[10:2] == 9'd0);
        dig_big      = !r_zero && !r_e[11] && (r_e[10:2] != 9'd0);
        dig_ip       = r_m[52:49] >> (2'd3 - r_e[1:0]);
        if (dig_big) begin
            dig_d = 4'd9;
        end else if (dig_in_range) begin
            dig_d = (dig_ip >= 4'd9) ? 4'd9 : dig_ip;
        end else begin
            dig_d = 4'd0;
        end
        dig_sub = {dig_d, 52'd0} >> r_e[1:0];
        sub_m   = r_m - dig_sub[52:0];
    end

    // One normalizing step: up to eight leading zeros per cycle.
    logic [3:0] nrm_lz;
    always_comb begin
        nrm_lz = 4'd8;
        for (int i = 0; i < 8; i++) begin
            if (r_m[45 + i]) begin
                nrm_lz = 4'(7 - i);
            end
        end
    end

    // Working value and flags.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_m     <= {1'b1, ld_frac};
            r_e     <= {1'b0, ld_exp} - EXP_BIAS;
            r_zero  <= (ld_exp == 11'd0);
            r_err   <= (ld_exp >= EXP_LIMIT);
            r_neg   <= i_value_bits[63] & ((ld_exp != 11'd0) | (ld_frac != 52'd0));
            r_small <= (ld_exp < EXP_ONE);
        end else if (i_cmd.round) begin
            r_m <= rnd_m;
            r_e <= rnd_e;
        end else if (i_cmd.sub) begin
            if (dig_in_range) begin
                r_m <= sub_m;
                if (sub_m == 53'd0) begin
                    r_zero <= 1'b1;
                end
            end
        end else if (i_cmd.norm) begin
            r_m <= r_m << nrm_lz;
            r_e <= r_e - {8'd0, nrm_lz};
        end
    end

    // Divider and product register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dq       <= {4'd0, r_m, 7'd0};
            r_rem      <= 4'd0;
            r_from_div <= 1'b1;
        end else if (i_cmd.mul) begin
            r_dq       <= {7'd0, mul_p};
            r_rem      <= 4'd0;
            r_from_div <= 1'b0;
        end else if (r_div_busy) begin
            r_dq  <= div_dq;
            r_rem <= div_rem;
        end
    end

    // Divider sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
            r_div_cnt  <= 3'd0;
        end else if (i_cmd.div_start) begin
            r_div_busy <= 1'b1;
            r_div_cnt  <= 3'd0;
        end else if (r_div_busy) begin
            r_div_cnt <= r_div_cnt + 3'd1;
            if (r_div_cnt == 3'd7) begin
                r_div_busy <= 1'b0;
            end
        end
    end

    // Status toward the controller.
    always_comb begin
        o_stat.err        = r_err;
        o_stat.neg        = r_neg;
        o_stat.below_one  = r_small;
        o_stat.ge_one     = !r_zero && !r_e[11];
        o_stat.div_busy   = r_div_busy;
        o_stat.norm_done  = r_zero | r_m[52];
        o_stat.digit_char = CH_ZERO + {4'd0, dig_d};
    end

`ifndef SYNTHESIS
    // A division keeps the divider busy until its step counter reaches seven.
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |=> ##7 (r_div_busy && r_div_cnt == 3'd7))
        else $error("divider length wrong");

    // The controller never issues work while the divider is running.
    a_div_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_busy |-> !(i_cmd.mul || i_cmd.round || i_cmd.sub || i_cmd.div_start))
        else $error("command during division");

    // A normalizing step is only asked for a nonzero unnormalized value.
    a_norm_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.norm |-> (!r_zero && !r_m[52]))
        else $error("bad normalize request");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/dtdc_ctrl.sv -----
// Controller: sequences sign, integer digit count, digit loop and point,
// and holds the result register toward the output channel.
// Depends on dtdc_pkg.
`default_nettype none

module dtdc_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [dtdc_pkg::PREC_W-1:0]  i_precision,
    output dtdc_pkg::t_dp_cmd            o_cmd,
    input  dtdc_pkg::t_dp_stat           i_stat,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [dtdc_pkg::CHAR_W-1:0]  o_character,
    output logic                         o_last,
    output logic                         o_out_of_range
);
    import dtdc_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_ERR    = 4'd2;
    localparam logic [3:0] S_SIGN   = 4'd3;
    localparam logic [3:0] S_ZERO   = 4'd4;
    localparam logic [3:0] S_POINT0 = 4'd5;
    localparam logic [3:0] S_DIV    = 4'd6;
    localparam logic [3:0] S_DIVW   = 4'd7;
    localparam logic [3:0] S_DIVC   = 4'd8;
    localparam logic [3:0] S_MUL    = 4'd9;
    localparam logic [3:0] S_RND    = 4'd10;
    localparam logic [3:0] S_DIG    = 4'd11;
    localparam logic [3:0] S_POINT  = 4'd12;
    localparam logic [3:0] S_NORM   = 4'd13;

    logic [3:0]        r_state, n_state;
    logic [PREC_W-1:0] r_prec, n_prec;
    logic [4:0]        r_int, n_int;
    logic [5:0]        r_t, n_t;
    logic              r_out_valid;
    logic [CHAR_W-1:0] r_out_char;
    logic              r_out_last;
    logic              r_out_oor;

    logic              out_free;
    logic [5:0]        total;
    logic              put;
    logic [CHAR_W-1:0] put_char;
    logic              put_last;
    logic              put_oor;

    assign out_free   = !r_out_valid || i_out_ready;
    assign total      = {1'b0, r_int} + {1'b0, r_prec};
    assign o_in_ready = (r_state == S_IDLE);

    // Next state and datapath commands.
    always_comb begin
        n_state  = r_state;
        n_prec   = r_prec;
        n_int    = r_int;
        n_t      = r_t;
        o_cmd    = '0;
        put      = 1'b0;
        put_char = CH_NONE;
        put_last = 1'b0;
        put_oor  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_prec     = (i_precision > PREC_MAX) ? PREC_MAX : i_precision;
                    n_int      = 5'd0;
                    n_t        = 6'd0;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.err) begin
                    n_state = S_ERR;
                end else if (i_stat.neg) begin
                    n_state = S_SIGN;
                end else if (i_stat.below_one) begin
                    n_state = S_ZERO;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_ERR: begin
                if (out_free) begin
                    put      = 1'b1;
                    put_last = 1'b1;
                    put_oor  = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_SIGN: begin
                if (out_free) begin
                    put      = 1'b1;
                    put_char = CH_MINUS;
                    n_state  = i_stat.below_one ? S_ZERO : S_DIV;
                end
            end
            S_ZERO: begin
                if (out_free) begin
                    put      = 1'b1;
                    put_char = CH_ZERO;
                    put_last = (r_prec == '0);
                    n_state  = (r_prec == '0) ? S_IDLE : S_POINT0;
                end
            end
            S_POINT0: begin
                if (out_free) begin
                    put      = 1'b1;
                    put_char = CH_POINT;
                    n_state  = S_MUL;
                end
            end
            S_DIV: begin
                o_cmd.div_start = 1'b1;
                n_int           = r_int + 5'd1;
                n_state         = S_DIVW;
            end
            S_DIVW: begin
                if (!i_stat.div_busy) begin
                    o_cmd.round = 1'b1;
                    n_state     = S_DIVC;
                end
            end
            S_DIVC: begin
                n_state = (i_stat.ge_one && r_int < INT_LIMIT) ? S_DIV : S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_RND;
            end
            S_RND: begin
                o_cmd.round = 1'b1;
                n_state     = S_DIG;
            end
            S_DIG: begin
                if (out_free) begin
                    put       = 1'b1;
                    put_char  = i_stat.digit_char;
                    put_last  = (r_t + 6'd1 == total);
                    o_cmd.sub = 1'b1;
                    n_t       = r_t + 6'd1;
                    if (r_t + 6'd1 == total) begin
                        n_state = S_IDLE;
                    end else if (r_t + 6'd1 == {1'b0, r_int} && r_prec != '0) begin
                        n_state = S_POINT;
                    end else begin
                        n_state = S_NORM;
                    end
                end
            end
            S_POINT: begin
                if (out_free) begin
                    put      = 1'b1;
                    put_char = CH_POINT;
                    n_state  = S_NORM;
                end
            end
            S_NORM: begin
                if (i_stat.norm_done) begin
                    n_state = S_MUL;
                end else begin
                    o_cmd.norm = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (put) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Counters and result payload.
    always_ff @(posedge i_clk) begin
        r_prec <= n_prec;
        r_int  <= n_int;
        r_t    <= n_t;
        if (put) begin
            r_out_char <= put_char;
            r_out_last <= put_last;
            r_out_oor  <= put_oor;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_character    = r_out_char;
    assign o_last         = r_out_last;
    assign o_out_of_range = r_out_oor;

`ifndef SYNTHESIS
    // An error item is a single last character of code zero.
    a_err_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_oor) |-> (r_out_last && r_out_char == CH_NONE))
        else $error("malformed error item");

    // The digit loop never runs past the requested count.
    a_digit_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIG) |-> (r_t < total))
        else $error("digit count overrun");

    // A magnitude below 2^31 has at most ten integer digits.
    a_int_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_int <= 5'd10))
        else $error("too many integer digits");

    // An accepted item always moves the controller on to decode.
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_CHECK))
        else $error("accept did not start conversion");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/double_to_decimal_chars.sv -----
// Double to decimal characters: input item is a binary64 value and a
// precision; results are ASCII characters of its truncated decimal text.
//
// Channels: i_in carries value_bits and precision; o_out carries one
// character per item with last on the final one, or a single item with
// out_of_range set and character zero for NaN, infinity or |x| >= 2^31.
// Both use valid/ready; an item moves on a clock edge with both high.
// One conversion is in flight at a time. After acceptance each integer
// digit takes a divide by ten (eight quotient bits per cycle) followed by
// rounding, and each output digit takes a multiply by ten, rounding,
// emission and renormalization (up to eight bit positions per cycle);
// the point is emitted as one more character where it follows.
// Input ready is high only while idle; it returns as soon as the last
// character is loaded into the output register, even if that character
// is still waiting to be taken.
// A stalled receiver freezes the conversion; no character is lost.
// Reset (synchronous, active low) returns the controller to idle and
// empties the output register.
// Depends on dtdc_pkg, dtdc_if, dtdc_datapath and dtdc_ctrl.
`default_nettype none

module double_to_decimal_chars (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dtdc_in_if.sink       i_in,
    dtdc_out_if.source    o_out
);
    import dtdc_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Arithmetic on the working double.
    dtdc_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_value_bits (i_in.value_bits),
        .o_stat       (stat)
    );

    // Sequencing and output register.
    dtdc_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in.valid),
        .o_in_ready     (i_in.ready),
        .i_precision    (i_in.precision),
        .o_cmd          (cmd),
        .i_stat         (stat),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_character    (o_out.character),
        .o_last         (o_out.last),
        .o_out_of_range (o_out.out_of_range)
    );

endmodule

`default_nettype wire
